// ----- rtl/core/pfd_pkg.sv -----
// pfd_pkg: shared types and constants of the ppm frame decoder
// used by the interfaces, the conditioning unit and the top level
package pfd_pkg;

	localparam int TS_W       = 32;
	localparam int PW_W       = 16;
	localparam int CH_IDX_W   = 3;
	localparam int CNT_REG_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_LENGTH   = 3'd0,
		REG_CHANNEL_COUNT = 3'd1,
		REG_PULSE_MAX     = 3'd2,
		REG_PULSE_MIN     = 3'd3,
		REG_DEADBAND_LOW  = 3'd4,
		REG_DEADBAND_HIGH = 3'd5,
		REG_CENTER_VALUE  = 3'd6
	} reg_idx_t;

	localparam logic [PW_W-1:0]      RST_SYNC_LENGTH   = 16'd4000;
	localparam logic [CNT_REG_W-1:0] RST_CHANNEL_COUNT = 4'd6;
	localparam logic [PW_W-1:0]      RST_PULSE_MAX     = 16'd2000;
	localparam logic [PW_W-1:0]      RST_PULSE_MIN     = 16'd1000;
	localparam logic [PW_W-1:0]      RST_DEADBAND_LOW  = 16'd1450;
	localparam logic [PW_W-1:0]      RST_DEADBAND_HIGH = 16'd1550;
	localparam logic [PW_W-1:0]      RST_CENTER_VALUE  = 16'd1500;

	typedef struct packed {
		logic [PW_W-1:0] pulse_max;
		logic [PW_W-1:0] pulse_min;
		logic [PW_W-1:0] deadband_low;
		logic [PW_W-1:0] deadband_high;
		logic [PW_W-1:0] center_value;
	} cond_cfg_t;

endpackage

// ----- rtl/core/pfd_if.sv -----
// pfd_if: valid/ready channel interfaces of the ppm frame decoder
// depends on pfd_pkg for field widths
interface pfd_in_if;
	logic                      valid;
	logic                      ready;
	logic                      edge_level;
	logic [pfd_pkg::TS_W-1:0]  timestamp;

	modport source (output valid, output edge_level, output timestamp, input ready);
	modport sink   (input valid, input edge_level, input timestamp, output ready);
endinterface

interface pfd_out_if;
	logic                          valid;
	logic                          ready;
	logic [pfd_pkg::CH_IDX_W-1:0]  channel_index;
	logic [pfd_pkg::PW_W-1:0]      pulse_width;
	logic                          last_channel;

	modport source (output valid, output channel_index, output pulse_width,
		output last_channel, input ready);
	modport sink   (input valid, input channel_index, input pulse_width,
		input last_channel, output ready);
endinterface

interface pfd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pfd_pkg::CFG_IDX_W-1:0]  index;
	logic [pfd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/pfd_cond.sv -----
// pfd_cond: clamp and deadband conditioning of one channel value
// depends on pfd_pkg for cond_cfg_t
module pfd_cond (
	input  logic [pfd_pkg::PW_W-1:0] value,
	input  pfd_pkg::cond_cfg_t       cond_cfg,
	output logic [pfd_pkg::PW_W-1:0] result
);

	logic [pfd_pkg::PW_W-1:0] hi_c;
	logic [pfd_pkg::PW_W-1:0] lo_c;

	always_comb begin
		hi_c = (value > cond_cfg.pulse_max) ? cond_cfg.pulse_max : value;
		lo_c = (hi_c < cond_cfg.pulse_min) ? cond_cfg.pulse_min : hi_c;
		if (lo_c < cond_cfg.deadband_high && lo_c > cond_cfg.deadband_low) begin
			result = cond_cfg.center_value;
		end else begin
			result = lo_c;
		end
	end

endmodule

// ----- rtl/core/ppm_frame_decoder_top.sv -----
// ppm_frame_decoder_top: pulse-position frame decoder for one rc ppm line
// depends on pfd_pkg, the pfd interfaces and pfd_cond
//
// edge_in carries one edge event per transfer (level after the edge, 32-bit
// tick timestamp). only falling edges act. a gap at or above sync_length
// starts a frame dump: every configured channel is read from the slot memory,
// clamped and deadbanded, written back and sent on chan_out, last_channel set
// on the final one. a shorter gap goes into the next free slot, if one is left.
// cfg takes register writes (index, data) in every cycle; write only when idle.
// a rising edge or short gap leaves the decoder idle, so edge_in stays ready.
// a sync with n channels holds edge_in while each channel passes a memory
// read state and a condition/write-back state on the single slot ram.
// the first result is loaded into the output register when S_COND finds it free.
// chan_out is registered: a stalled receiver holds the result and the slot
// sequencer waits; a finished frame's last result may wait while new edges are
// taken. reset clears config to defaults, slot valid bits (slots read as zero),
// the slot pointer and the previous edge time; no clearing pass is needed.
module ppm_frame_decoder_top #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	pfd_cfg_if.sink      cfg,
	pfd_in_if.sink       edge_in,
	pfd_out_if.source    chan_out
);

	localparam int CW = $clog2(MAX_CHANNELS + 1);
	localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_COND
	} state_t;

	state_t                        state_q;
	logic [pfd_pkg::TS_W-1:0]      prev_q;
	logic [CW-1:0]                 slot_q;
	logic [IW-1:0]                 idx_q;
	logic [pfd_pkg::PW_W-1:0]      sync_q;
	logic [pfd_pkg::CNT_REG_W-1:0] cc_q;
	pfd_pkg::cond_cfg_t            cond_cfg_q;
	logic [MAX_CHANNELS-1:0]       vld_q;

	logic [pfd_pkg::PW_W-1:0]      mem [MAX_CHANNELS];
	logic [pfd_pkg::PW_W-1:0]      rd_data_s1;
	logic                          rd_vld_s1;

	logic                          out_vld_q;
	logic [pfd_pkg::CH_IDX_W-1:0]  out_idx_q;
	logic [pfd_pkg::PW_W-1:0]      out_pw_q;
	logic                          out_last_q;

	logic [CW-1:0]                 n_c;
	logic [pfd_pkg::TS_W-1:0]      gap_c;
	logic                          is_sync_c;
	logic                          take_c;
	logic                          store_wr_c;
	logic [IW-1:0]                 store_addr_c;
	logic [pfd_pkg::PW_W-1:0]      rd_val_c;
	logic [pfd_pkg::PW_W-1:0]      cond_c;
	logic                          out_free_c;
	logic                          wb_c;
	logic                          last_c;

	assign cfg.ready     = 1'b1;
	assign edge_in.ready = (state_q == S_IDLE);

	assign chan_out.valid         = out_vld_q;
	assign chan_out.channel_index = out_idx_q;
	assign chan_out.pulse_width   = out_pw_q;
	assign chan_out.last_channel  = out_last_q;

	always_comb begin
		if (32'(cc_q) > MAX_CHANNELS) begin
			n_c = CW'(MAX_CHANNELS);
		end else begin
			n_c = CW'(cc_q);
		end
	end

	assign gap_c        = edge_in.timestamp - prev_q;
	assign is_sync_c    = gap_c >= {{(pfd_pkg::TS_W - pfd_pkg::PW_W){1'b0}}, sync_q};
	assign take_c       = edge_in.valid && (state_q == S_IDLE) && !edge_in.edge_level;
	assign store_wr_c   = take_c && !is_sync_c && (slot_q < n_c);
	assign store_addr_c = slot_q[IW-1:0];
	assign rd_val_c     = rd_vld_s1 ? rd_data_s1 : '0;
	assign out_free_c   = !out_vld_q || chan_out.ready;
	assign wb_c         = (state_q == S_COND) && out_free_c;
	assign last_c       = (32'(idx_q) + 32'd1) == 32'(n_c);

	pfd_cond u_cond (
		.value    (rd_val_c),
		.cond_cfg (cond_cfg_q),
		.result   (cond_c)
	);

	// slot memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wb_c) begin
			mem[idx_q] <= cond_c;
		end else if (store_wr_c) begin
			mem[store_addr_c] <= gap_c[pfd_pkg::PW_W-1:0];
		end
		if (state_q == S_READ) begin
			rd_data_s1 <= mem[idx_q];
			rd_vld_s1  <= vld_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			prev_q     <= '0;
			slot_q     <= '0;
			idx_q      <= '0;
			vld_q      <= '0;
			sync_q     <= pfd_pkg::RST_SYNC_LENGTH;
			cc_q       <= pfd_pkg::RST_CHANNEL_COUNT;
			cond_cfg_q <= '{pulse_max:     pfd_pkg::RST_PULSE_MAX,
				pulse_min:     pfd_pkg::RST_PULSE_MIN,
				deadband_low:  pfd_pkg::RST_DEADBAND_LOW,
				deadband_high: pfd_pkg::RST_DEADBAND_HIGH,
				center_value:  pfd_pkg::RST_CENTER_VALUE};
			out_vld_q  <= 1'b0;
			out_idx_q  <= '0;
			out_pw_q   <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					pfd_pkg::REG_SYNC_LENGTH:   sync_q <= cfg.data;
					pfd_pkg::REG_CHANNEL_COUNT: cc_q <= cfg.data[pfd_pkg::CNT_REG_W-1:0];
					pfd_pkg::REG_PULSE_MAX:     cond_cfg_q.pulse_max <= cfg.data;
					pfd_pkg::REG_PULSE_MIN:     cond_cfg_q.pulse_min <= cfg.data;
					pfd_pkg::REG_DEADBAND_LOW:  cond_cfg_q.deadband_low <= cfg.data;
					pfd_pkg::REG_DEADBAND_HIGH: cond_cfg_q.deadband_high <= cfg.data;
					pfd_pkg::REG_CENTER_VALUE:  cond_cfg_q.center_value <= cfg.data;
					default: ;
				endcase
			end

			if (out_vld_q && chan_out.ready && !wb_c) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (take_c) begin
						prev_q <= edge_in.timestamp;
						if (is_sync_c) begin
							slot_q <= '0;
							idx_q  <= '0;
							if (n_c != '0) begin
								state_q <= S_READ;
							end
						end else if (store_wr_c) begin
							slot_q               <= slot_q + 1'b1;
							vld_q[store_addr_c]  <= 1'b1;
						end
					end
				end
				S_READ: begin
					state_q <= S_COND;
				end
				S_COND: begin
					if (out_free_c) begin
						vld_q[idx_q] <= 1'b1;
						out_vld_q    <= 1'b1;
						out_idx_q    <= pfd_pkg::CH_IDX_W'(idx_q);
						out_pw_q     <= cond_c;
						out_last_q   <= last_c;
						if (last_c) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/pfd_checker.sv -----
// pfd_checker: port-level assertions for ppm_frame_decoder_top
// attached by the bind statement at the end of this file
module pfd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pfd_pkg::CH_IDX_W-1:0]  out_index,
	input logic [pfd_pkg::PW_W-1:0]      out_width,
	input logic                          out_last
);

	logic [pfd_pkg::CH_IDX_W-1:0] exp_idx_q;

	// channel index expected on the next output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= out_last ? '0 : out_index + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_index) && $stable(out_width)
			&& $stable(out_last))
		else $error("output payload changed while stalled");

	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_index == exp_idx_q)
		else $error("channel index out of sequence");

	a_busy_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		exp_idx_q != '0 && !out_valid |-> !in_ready)
		else $error("edge input ready in the middle of a frame dump");

endmodule

bind ppm_frame_decoder_top pfd_checker u_pfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (edge_in.ready),
	.out_valid (chan_out.valid),
	.out_ready (chan_out.ready),
	.out_index (chan_out.channel_index),
	.out_width (chan_out.pulse_width),
	.out_last  (chan_out.last_channel)
);
